// ===== rtl/ivf_pkg.sv =====
// ----------------------------------------------------------------------------
// ivf_pkg: shared types and constants of the IPv4 frame validator
// Header offsets, protocol constants, verdict codes and the per-frame record
// that the parser hands to the verdict stage.
// ----------------------------------------------------------------------------
package ivf_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] IP_MIN_BYTES   = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [15:0] ICMP_HDR_BYTES = 16'd12;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [31:0] ICMP_MAGIC     = 32'h1234_5678;
    localparam logic [15:0] WORD_MASK      = 16'hFFFF;

    // Verdict codes, first failed check in order
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_ETH_SHORT  = 4'd1;
    localparam logic [3:0] ERR_ETHERTYPE  = 4'd2;
    localparam logic [3:0] ERR_IP_SHORT   = 4'd3;
    localparam logic [3:0] ERR_TOTAL_LEN  = 4'd4;
    localparam logic [3:0] ERR_VERSION    = 4'd5;
    localparam logic [3:0] ERR_CHECKSUM   = 4'd6;
    localparam logic [3:0] ERR_PROTOCOL   = 4'd7;
    localparam logic [3:0] ERR_UDP_SHORT  = 4'd8;
    localparam logic [3:0] ERR_UDP_LEN    = 4'd9;
    localparam logic [3:0] ERR_ICMP_SHORT = 4'd10;
    localparam logic [3:0] ERR_ICMP_ECHO  = 4'd11;

    // Everything the verdict needs about one finished frame
    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] eth_type;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [15:0] csum;
        logic [31:0] source_ip;
        logic [15:0] l4_word0;
        logic [15:0] l4_word1;
        logic [15:0] l4_word2;
        logic [15:0] l4_word3;
        logic [31:0] icmp_payload;
    } frame_rec_t;

endpackage

// ===== rtl/ivf_in_if.sv =====
// ----------------------------------------------------------------------------
// ivf_in_if: frame byte channel
// One frame byte per request, with a marker on the final byte.
// ----------------------------------------------------------------------------
interface ivf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/ivf_out_if.sv =====
// ----------------------------------------------------------------------------
// ivf_out_if: verdict channel
// One verdict request per frame, with the captured header fields.
// ----------------------------------------------------------------------------
interface ivf_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  error_code;
    logic        is_udp;
    logic [31:0] source_ip;
    logic [15:0] icmp_sequence;
    logic [15:0] udp_source_port;
    logic [15:0] udp_dest_port;
    logic [15:0] frame_length;

    modport source (output valid, output error_code, output is_udp, output source_ip,
                    output icmp_sequence, output udp_source_port, output udp_dest_port,
                    output frame_length, input ready);
    modport sink   (input valid, input error_code, input is_udp, input source_ip,
                    input icmp_sequence, input udp_source_port, input udp_dest_port,
                    input frame_length, output ready);
endinterface

// ===== rtl/ivf_front.sv =====
// ----------------------------------------------------------------------------
// ivf_front: byte parser
// Counts bytes, captures header fields and folds the IPv4 header checksum.
// On the final byte it pushes one frame record and clears for the next frame.
// ----------------------------------------------------------------------------
module ivf_front (
    input  logic               clk,
    input  logic               rst_n,
    ivf_in_if.sink             frame_in,
    input  logic               q_full,
    output logic               q_push,
    output ivf_pkg::frame_rec_t q_rec
);
    import ivf_pkg::*;

    logic [15:0] count_reg, count_next;
    logic [16:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] ether_reg, ether_next;
    logic [7:0]  vihl_reg, vihl_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] sip_reg, sip_next;
    logic [15:0] l4_reg [4];
    logic [15:0] l4_next [4];
    logic [31:0] pay_reg, pay_next;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] l4_off;
    logic [1:0]  l4_k;
    logic [16:0] hdr_end;
    logic        in_hdr;
    logic [15:0] add_word;
    logic        do_add;

    // Add one word with end-around carry folded back
    function automatic logic [16:0] csum_add(logic [16:0] acc, logic [15:0] w);
        logic [17:0] s;
        logic [16:0] f;
        s = {1'b0, acc} + {2'b00, w};
        f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        return f;
    endfunction

    assign frame_in.ready = !q_full;
    assign accept         = frame_in.valid && frame_in.ready;
    assign b              = frame_in.data_byte;
    assign l4_off         = count_reg - 16'd34;
    assign l4_k           = l4_off[2:1];

    // Capture header fields at their fixed offsets
    always_comb
    begin
        ether_next = ether_reg;
        vihl_next  = vihl_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        sip_next   = sip_reg;
        pay_next   = pay_reg;
        for (int i = 0; i < 4; i++)
        begin
            l4_next[i] = l4_reg[i];
        end
        if (count_reg == 16'd12 || count_reg == 16'd13)
        begin
            ether_next = {ether_reg[7:0], b};
        end
        if (count_reg == 16'd14)
        begin
            vihl_next = b;
        end
        if (count_reg == 16'd16 || count_reg == 16'd17)
        begin
            tlen_next = {tlen_reg[7:0], b};
        end
        if (count_reg == 16'd23)
        begin
            proto_next = b;
        end
        if (count_reg >= 16'd26 && count_reg <= 16'd29)
        begin
            sip_next = {sip_reg[23:0], b};
        end
        if (count_reg >= 16'd34 && count_reg <= 16'd41)
        begin
            l4_next[l4_k] = {l4_reg[l4_k][7:0], b};
        end
        if (count_reg >= 16'd42 && count_reg <= 16'd45)
        begin
            pay_next = {pay_reg[23:0], b};
        end
    end

    // Accumulate the header checksum over 4*IHL bytes from offset 14
    assign hdr_end = {1'b0, ETH_HDR_BYTES} + {11'd0, vihl_next[3:0], 2'b00};
    assign in_hdr  = (count_reg >= ETH_HDR_BYTES) && ({1'b0, count_reg} < hdr_end);

    always_comb
    begin
        hold_next = hold_reg;
        add_word  = {hold_reg, b};
        do_add    = 1'b0;
        if (in_hdr)
        begin
            if (!count_reg[0])
            begin
                hold_next = b;
                add_word  = {b, 8'd0};
                do_add    = frame_in.last_byte;
            end
            else
            begin
                do_add = 1'b1;
            end
        end
        sum_next   = do_add ? csum_add(sum_reg, add_word) : sum_reg;
        count_next = (count_reg == WORD_MASK) ? count_reg : count_reg + 16'd1;
    end

    // Build the record from the values after this byte
    always_comb
    begin
        q_rec.frame_length = count_next;
        q_rec.eth_type     = ether_next;
        q_rec.version_ihl  = vihl_next;
        q_rec.total_length = tlen_next;
        q_rec.protocol     = proto_next;
        q_rec.csum         = sum_next[15:0];
        q_rec.source_ip    = sip_next;
        q_rec.l4_word0     = l4_next[0];
        q_rec.l4_word1     = l4_next[1];
        q_rec.l4_word2     = l4_next[2];
        q_rec.l4_word3     = l4_next[3];
        q_rec.icmp_payload = pay_next;
    end

    assign q_push = accept && frame_in.last_byte;

    // Advance per byte; clear all per-frame state after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            ether_reg <= '0;
            vihl_reg  <= '0;
            tlen_reg  <= '0;
            proto_reg <= '0;
            sip_reg   <= '0;
            pay_reg   <= '0;
            for (int i = 0; i < 4; i++)
            begin
                l4_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (frame_in.last_byte)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                hold_reg  <= '0;
                ether_reg <= '0;
                vihl_reg  <= '0;
                tlen_reg  <= '0;
                proto_reg <= '0;
                sip_reg   <= '0;
                pay_reg   <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    l4_reg[i] <= '0;
                end
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                hold_reg  <= hold_next;
                ether_reg <= ether_next;
                vihl_reg  <= vihl_next;
                tlen_reg  <= tlen_next;
                proto_reg <= proto_next;
                sip_reg   <= sip_next;
                pay_reg   <= pay_next;
                for (int i = 0; i < 4; i++)
                begin
                    l4_reg[i] <= l4_next[i];
                end
            end
        end
    end

endmodule

// ===== rtl/ivf_queue.sv =====
// ----------------------------------------------------------------------------
// ivf_queue: frame record queue
// Short FIFO of finished frame records between the parser and the verdict
// stage, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ivf_queue #(
    parameter int unsigned Depth = ivf_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ivf_pkg::frame_rec_t push_rec,
    output logic                full,
    output logic                head_valid,
    output ivf_pkg::frame_rec_t head_rec,
    input  logic                pop
);
    import ivf_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

    frame_rec_t      entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full       = (cnt_reg == DepthCnt);
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed record
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== rtl/ivf_back.sv =====
// ----------------------------------------------------------------------------
// ivf_back: verdict stage
// Runs the ordered checks on one frame record and holds the verdict in an
// output register until the sink takes it.
// ----------------------------------------------------------------------------
module ivf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ivf_pkg::frame_rec_t head_rec,
    output logic                pop,
    ivf_out_if.source           verdict_out
);
    import ivf_pkg::*;

    logic        valid_reg;
    logic [3:0]  code_reg, code_next;
    logic        udp_reg, udp_next;
    logic [31:0] sip_reg, sip_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [15:0] len_reg;

    logic [15:0] len;
    logic [15:0] ihl4;
    logic [16:0] ip_len;
    logic        is_udp_proto;

    assign len          = head_rec.frame_length;
    assign ihl4         = {10'd0, head_rec.version_ihl[3:0], 2'b00};
    assign ip_len       = {1'b0, head_rec.total_length} + {1'b0, ETH_HDR_BYTES};
    assign is_udp_proto = (head_rec.protocol == PROTO_UDP);

    // Take the first failed check in order
    always_comb
    begin
        code_next = ERR_NONE;
        if (len < ETH_HDR_BYTES)
        begin
            code_next = ERR_ETH_SHORT;
        end
        else if (head_rec.eth_type != ETHERTYPE_IPV4)
        begin
            code_next = ERR_ETHERTYPE;
        end
        else if (len < ETH_HDR_BYTES + IP_MIN_BYTES)
        begin
            code_next = ERR_IP_SHORT;
        end
        else if ({1'b0, len} != ip_len)
        begin
            code_next = ERR_TOTAL_LEN;
        end
        else if (head_rec.version_ihl[7:4] != 4'd4)
        begin
            code_next = ERR_VERSION;
        end
        else if (head_rec.csum != WORD_MASK)
        begin
            code_next = ERR_CHECKSUM;
        end
        else if (!is_udp_proto && head_rec.protocol != PROTO_ICMP)
        begin
            code_next = ERR_PROTOCOL;
        end
        else if (is_udp_proto)
        begin
            if (len < ETH_HDR_BYTES + IP_MIN_BYTES + UDP_HDR_BYTES)
            begin
                code_next = ERR_UDP_SHORT;
            end
            else if (head_rec.total_length < ihl4 ||
                     head_rec.l4_word2 != head_rec.total_length - ihl4)
            begin
                code_next = ERR_UDP_LEN;
            end
        end
        else
        begin
            if (len < ETH_HDR_BYTES + IP_MIN_BYTES + ICMP_HDR_BYTES)
            begin
                code_next = ERR_ICMP_SHORT;
            end
            else if (head_rec.l4_word0 != 16'd0 || head_rec.icmp_payload != ICMP_MAGIC)
            begin
                code_next = ERR_ICMP_ECHO;
            end
        end
    end

    // Zero the fields of a failed frame
    always_comb
    begin
        udp_next   = 1'b0;
        sip_next   = '0;
        seq_next   = '0;
        sport_next = '0;
        dport_next = '0;
        if (code_next == ERR_NONE)
        begin
            sip_next = head_rec.source_ip;
            if (is_udp_proto)
            begin
                udp_next   = 1'b1;
                sport_next = head_rec.l4_word0;
                dport_next = head_rec.l4_word1;
            end
            else
            begin
                seq_next = head_rec.l4_word3;
            end
        end
    end

    // Load the output register when it is empty or being drained
    assign pop = head_valid && (!valid_reg || verdict_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || verdict_out.ready)
        begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg  <= code_next;
            udp_reg   <= udp_next;
            sip_reg   <= sip_next;
            seq_reg   <= seq_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            len_reg   <= len;
        end
    end

    assign verdict_out.valid           = valid_reg;
    assign verdict_out.error_code      = code_reg;
    assign verdict_out.is_udp          = udp_reg;
    assign verdict_out.source_ip       = sip_reg;
    assign verdict_out.icmp_sequence   = seq_reg;
    assign verdict_out.udp_source_port = sport_reg;
    assign verdict_out.udp_dest_port   = dport_reg;
    assign verdict_out.frame_length    = len_reg;

endmodule

// ===== rtl/ipv4_frame_validator.sv =====
// ----------------------------------------------------------------------------
// ipv4_frame_validator: IPv4 frame header validator
// Byte-stream Ethernet/IPv4 checker that gives one verdict per frame.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per clock while frame_in is ready, in wire
// order, with last_byte marking the end of a frame. The parser captures
// header fields and folds the IPv4 header checksum as bytes pass. On the
// final byte a frame record enters a QueueDepth-entry queue; the verdict
// stage runs the ordered checks on the queue head and loads the verdict into
// the output register on verdict_out once that register is empty or drained.
// Ready on frame_in drops only while that queue is full, which happens when
// the sink holds off and frames keep ending. Frames may follow back to back.
module ipv4_frame_validator #(
    parameter int unsigned QueueDepth = ivf_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ivf_in_if.sink    frame_in,
    ivf_out_if.source verdict_out
);
    import ivf_pkg::*;

    logic       q_push;
    frame_rec_t q_push_rec;
    logic       q_full;
    logic       q_head_valid;
    frame_rec_t q_head_rec;
    logic       q_pop;

    ivf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (q_push_rec)
    );

    ivf_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (q_push_rec),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_rec   (q_head_rec),
        .pop        (q_pop)
    );

    ivf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_rec    (q_head_rec),
        .pop         (q_pop),
        .verdict_out (verdict_out)
    );

endmodule

// ===== tb/sv/ivf_verdict_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ivf_verdict_checker: frame verdict predictor and scoreboard
// Mirrors the validator byte by byte: captures header fields, folds the IPv4
// header sum, and on each last byte queues the verdict the block must give.
// Verdicts taken from the block are compared in order, field by field.
// ----------------------------------------------------------------------------
package ivf_tb_pkg;

    import ivf_pkg::*;

    typedef struct packed {
        logic [3:0]  code;
        logic        is_udp;
        logic [31:0] source_ip;
        logic [15:0] icmp_sequence;
        logic [15:0] udp_source_port;
        logic [15:0] udp_dest_port;
        logic [15:0] frame_length;
    } verdict_t;

    class ivf_verdict_checker;

        logic [15:0] byte_count;
        logic [16:0] csum_acc;
        logic [7:0]  word_hi;
        logic [15:0] eth_type;
        logic [7:0]  ver_ihl;
        logic [15:0] total_len;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [15:0] l4_word [4];
        logic [31:0] icmp_payload;

        verdict_t    pending_verdicts [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count   = '0;
            csum_acc     = '0;
            word_hi      = '0;
            eth_type     = '0;
            ver_ihl      = '0;
            total_len    = '0;
            protocol     = '0;
            src_ip       = '0;
            icmp_payload = '0;
            for (int k = 0; k < 4; k++) l4_word[k] = '0;
        endfunction

        // Add one header word with end-around carry
        function void fold_word(logic [15:0] w);
            logic [17:0] s;
            s = {1'b0, csum_acc} + {2'b00, w};
            s = {2'b00, s[15:0]} + {16'h0000, s[17:16]};
            csum_acc = s[16:0];
        endfunction

        // First failed check, in the fixed order
        function logic [3:0] judge();
            int unsigned len;
            int unsigned tl;
            int unsigned ihl4;
            len  = byte_count;
            tl   = total_len;
            ihl4 = int'(ver_ihl[3:0]) * 4;
            if (len < ETH_HDR_BYTES) return ERR_ETH_SHORT;
            if (eth_type != ETHERTYPE_IPV4) return ERR_ETHERTYPE;
            if (len < ETH_HDR_BYTES + IP_MIN_BYTES) return ERR_IP_SHORT;
            if (len != tl + ETH_HDR_BYTES) return ERR_TOTAL_LEN;
            if (ver_ihl[7:4] != 4'd4) return ERR_VERSION;
            if (csum_acc[15:0] != WORD_MASK) return ERR_CHECKSUM;
            if (protocol != PROTO_UDP && protocol != PROTO_ICMP) return ERR_PROTOCOL;
            if (protocol == PROTO_UDP)
            begin
                if (len < ETH_HDR_BYTES + IP_MIN_BYTES + UDP_HDR_BYTES) return ERR_UDP_SHORT;
                if (tl < ihl4 || int'(l4_word[2]) != tl - ihl4) return ERR_UDP_LEN;
            end
            else
            begin
                if (len < ETH_HDR_BYTES + IP_MIN_BYTES + ICMP_HDR_BYTES) return ERR_ICMP_SHORT;
                if (l4_word[0] != 16'h0000 || icmp_payload != ICMP_MAGIC) return ERR_ICMP_ECHO;
            end
            return ERR_NONE;
        endfunction

        // Note one accepted frame byte; queue a verdict on the last byte
        function void take_byte(logic [7:0] b, logic lst);
            int unsigned idx;
            int unsigned ihl4;
            int unsigned k;
            logic [3:0]  code;
            verdict_t    v;
            idx = byte_count;

            // capture header fields at fixed offsets
            if (idx == 12 || idx == 13) eth_type = {eth_type[7:0], b};
            if (idx == 14) ver_ihl = b;
            if (idx == 16 || idx == 17) total_len = {total_len[7:0], b};
            if (idx == 23) protocol = b;
            if (idx >= 26 && idx <= 29) src_ip = {src_ip[23:0], b};
            if (idx >= 34 && idx <= 41)
            begin
                k = (idx - 34) >> 1;
                l4_word[k] = {l4_word[k][7:0], b};
            end
            if (idx >= 42 && idx <= 45) icmp_payload = {icmp_payload[23:0], b};

            // sum the IP header span; a lone high byte at frame end pads with zero
            ihl4 = int'(ver_ihl[3:0]) * 4;
            if (idx >= ETH_HDR_BYTES && idx < ETH_HDR_BYTES + ihl4)
            begin
                if (((idx - ETH_HDR_BYTES) & 1) == 0)
                begin
                    word_hi = b;
                    if (lst) fold_word({b, 8'h00});
                end
                else
                begin
                    fold_word({word_hi, b});
                end
            end

            // saturate the byte count
            if (byte_count != WORD_MASK) byte_count = byte_count + 16'd1;
            if (!lst) return;

            code           = judge();
            v              = '0;
            v.code         = code;
            v.frame_length = byte_count;
            if (code == ERR_NONE)
            begin
                v.source_ip = src_ip;
                if (protocol == PROTO_UDP)
                begin
                    v.is_udp          = 1'b1;
                    v.udp_source_port = l4_word[0];
                    v.udp_dest_port   = l4_word[1];
                end
                else
                begin
                    v.icmp_sequence = l4_word[3];
                end
            end
            pending_verdicts.push_back(v);
            clear_frame();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("verdict field %s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare a verdict from the block with the oldest expectation
        function void compare_verdict(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict with none expected: code %0d length %0d",
                       got.code, got.frame_length);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            check_field("error_code", want.code, got.code);
            check_field("is_udp", want.is_udp, got.is_udp);
            check_field("source_ip", want.source_ip, got.source_ip);
            check_field("icmp_sequence", want.icmp_sequence, got.icmp_sequence);
            check_field("udp_source_port", want.udp_source_port, got.udp_source_port);
            check_field("udp_dest_port", want.udp_dest_port, got.udp_dest_port);
            check_field("frame_length", want.frame_length, got.frame_length);
        endfunction

        function int unsigned pending();
            return pending_verdicts.size();
        endfunction

    endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: IPv4 frame validator testbench
// Streams directed and random Ethernet frames into the validator: well-formed
// UDP/ICMP frames with random content, broken frames and noise frames,
// with random idling on both channels and one long verdict stall.
// Every verdict is checked against a byte-level predictor.
// ----------------------------------------------------------------------------
module testbench;

    import ivf_pkg::*;
    import ivf_tb_pkg::*;

    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 16;
    localparam int unsigned RANDOM_FRAMES    = 12;
    localparam int unsigned QUIET_FRAMES     = 3;
    localparam int unsigned PRESSURE_START   = 2;
    localparam int unsigned PRESSURE_FRAMES  = 6;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bit          idle_on       = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned sent_bytes    = 0;
    logic [7:0]  frame_bytes [$];

    ivf_verdict_checker verdicts = new();

    ivf_in_if  frame_in ();
    ivf_out_if verdict_out ();

    ipv4_frame_validator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_in    (frame_in),
        .verdict_out (verdict_out)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Write a big-endian 16-bit field where the frame is long enough
    function automatic void set_u16(int unsigned idx, logic [15:0] v);
        if (idx + 1 < frame_bytes.size())
        begin
            frame_bytes[idx]     = v[15:8];
            frame_bytes[idx + 1] = v[7:0];
        end
    endfunction

    // Recompute the header checksum over the IHL span present in the frame
    function automatic void seal_header();
        int unsigned span;
        int unsigned acc;
        logic [15:0] w;
        span = 14 + 4 * frame_bytes[14][3:0];
        if (span > frame_bytes.size()) span = frame_bytes.size();
        set_u16(24, 16'h0000);
        acc = 0;
        for (int unsigned i = 14; i < span; i += 2)
        begin
            w = {frame_bytes[i], (i + 1 < span) ? frame_bytes[i + 1] : 8'h00};
            acc += w;
        end
        while (acc > 32'h0000_FFFF) acc = (acc & 32'h0000_FFFF) + (acc >> 16);
        set_u16(24, ~acc[15:0]);
    endfunction

    // Build a well-formed UDP or ICMP echo reply frame with random content
    function automatic void make_frame(bit udp, int unsigned ihl, int unsigned payload);
        int unsigned len;
        len = 34 + (udp ? 8 : 12) + payload;
        if (len < 14 + 4 * ihl) len = 14 + 4 * ihl;
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom));
        set_u16(12, ETHERTYPE_IPV4);
        frame_bytes[14] = {4'd4, 4'(ihl)};
        set_u16(16, 16'(len - 14));
        frame_bytes[23] = udp ? PROTO_UDP : PROTO_ICMP;
        if (udp)
        begin
            set_u16(38, 16'(len - 14 - 4 * ihl));
        end
        else
        begin
            set_u16(34, 16'h0000);
            set_u16(42, ICMP_MAGIC[31:16]);
            set_u16(44, ICMP_MAGIC[15:0]);
        end
        seal_header();
    endfunction

    // Random bytes, sometimes with an IPv4 ethertype and header start
    function automatic void make_noise(int unsigned len);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1)
        begin
            set_u16(12, ETHERTYPE_IPV4);
            if (len > 14) frame_bytes[14] = 8'h45;
        end
    endfunction

    // Break one aspect of a well-formed frame
    function automatic void break_frame();
        int unsigned idx;
        int unsigned n;
        case ($urandom_range(0, 10))
            0:
            begin
                idx = $urandom_range(0, frame_bytes.size() - 1);
                frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            1: set_u16(12, 16'($urandom));
            2:
            begin
                n = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
            end
            3: repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
            4:
            begin
                frame_bytes[14] = {4'($urandom), frame_bytes[14][3:0]};
                seal_header();
            end
            5:
            begin
                frame_bytes[23] = 8'($urandom);
                seal_header();
            end
            6:
            begin
                set_u16(38, 16'($urandom));
                seal_header();
            end
            7:
            begin
                frame_bytes[34 + $urandom_range(0, 1)] = 8'($urandom);
                seal_header();
            end
            8:
            begin
                idx = 42 + $urandom_range(0, 3);
                if (idx < frame_bytes.size()) frame_bytes[idx] ^= 8'($urandom_range(1, 255));
                seal_header();
            end
            9:
            begin
                frame_bytes[14] = {frame_bytes[14][7:4], 4'($urandom)};
                seal_header();
            end
            default:
            begin
                set_u16(16, 16'($urandom));
                seal_header();
            end
        endcase
    endfunction

    // Stream the built frame one byte per request, with random idle bursts
    task automatic send_frame();
        logic lst;
        for (int unsigned i = 0; i < frame_bytes.size(); i++)
        begin
            lst = (i == frame_bytes.size() - 1);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                frame_in.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            frame_in.valid     <= 1'b1;
            frame_in.data_byte <= frame_bytes[i];
            frame_in.last_byte <= lst;
            @(posedge clk);
            while (!frame_in.ready) @(posedge clk);
            verdicts.take_byte(frame_bytes[i], lst);
            sent_bytes++;
        end
    endtask

    task automatic run_directed();
        // runts, wrong ethertype, no room for the IP header
        make_noise(1);
        send_frame();
        make_noise(13);
        send_frame();
        make_noise(14);
        set_u16(12, 16'h86DD);
        send_frame();
        make_noise(20);
        set_u16(12, ETHERTYPE_IPV4);
        send_frame();

        // clean frames at field extremes
        make_frame(1, 5, 0);
        set_u16(26, 16'hFFFF);
        set_u16(28, 16'hFFFF);
        set_u16(34, 16'hFFFF);
        set_u16(36, 16'hFFFF);
        seal_header();
        send_frame();
        make_frame(1, 5, 2);
        set_u16(26, 16'h0000);
        set_u16(28, 16'h0000);
        set_u16(34, 16'h0000);
        set_u16(36, 16'h0000);
        seal_header();
        send_frame();
        make_frame(0, 5, 0);
        set_u16(40, 16'hFFFF);
        seal_header();
        send_frame();
        make_frame(1, 15, 0);
        send_frame();

        // length mismatch, version, checksum, zero IHL, protocol
        make_frame(1, 5, 3);
        frame_bytes.push_back(8'hA5);
        send_frame();
        make_frame(0, 5, 1);
        frame_bytes[14] = 8'h65;
        seal_header();
        send_frame();
        make_frame(1, 5, 1);
        frame_bytes[24] = frame_bytes[24] ^ 8'h01;
        send_frame();
        make_frame(1, 5, 0);
        frame_bytes[14] = 8'h40;
        seal_header();
        send_frame();
        make_frame(1, 5, 0);
        frame_bytes[23] = 8'd6;
        seal_header();
        send_frame();

        // UDP too short for its header, wrong UDP length
        make_frame(1, 5, 0);
        repeat (2) void'(frame_bytes.pop_back());
        set_u16(16, 16'd26);
        seal_header();
        send_frame();
        make_frame(1, 5, 4);
        set_u16(38, 16'hFFFF);
        seal_header();
        send_frame();

        // IHL past the frame end: total length below the header size,
        // once ending on a full word and once on a lone high byte
        make_frame(1, 5, 4);
        frame_bytes[14] = 8'h4F;
        seal_header();
        send_frame();
        make_frame(1, 5, 5);
        frame_bytes[14] = 8'h4F;
        seal_header();
        send_frame();

        // ICMP too short, wrong type, wrong code, wrong payload word
        make_frame(0, 5, 0);
        repeat (2) void'(frame_bytes.pop_back());
        set_u16(16, 16'd30);
        seal_header();
        send_frame();
        make_frame(0, 5, 0);
        frame_bytes[34] = 8'd8;
        seal_header();
        send_frame();
        make_frame(0, 5, 0);
        frame_bytes[35] = 8'd1;
        seal_header();
        send_frame();
        make_frame(0, 5, 3);
        frame_bytes[45] = frame_bytes[45] ^ 8'h80;
        seal_header();
        send_frame();
    endtask

    task automatic run_random();
        int unsigned pick;
        int unsigned payload;
        int unsigned ihl;
        for (int unsigned n = 0; n < RANDOM_FRAMES; n++)
        begin
            idle_on = (n < RANDOM_FRAMES - QUIET_FRAMES);
            if (n == PRESSURE_START) long_hold_req = 1'b1;
            if (n >= PRESSURE_START && n < PRESSURE_START + PRESSURE_FRAMES)
            begin
                // short frames while the verdict side holds off
                make_noise($urandom_range(1, 12));
            end
            else
            begin
                pick    = $urandom_range(0, 99);
                payload = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 6);
                ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
                if (pick < 85)
                begin
                    make_frame($urandom_range(0, 1), ihl, payload);
                    if (pick >= 60) break_frame();
                end
                else
                begin
                    make_noise($urandom_range(1, 70));
                end
            end
            send_frame();
        end
    endtask

    // Verdict side: take and check verdicts, stall in random bursts and once for a long hold
    initial
    begin
        verdict_t    got;
        int unsigned stall_left;
        stall_left = 0;
        verdict_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (verdict_out.valid && verdict_out.ready)
            begin
                got.code            = verdict_out.error_code;
                got.is_udp          = verdict_out.is_udp;
                got.source_ip       = verdict_out.source_ip;
                got.icmp_sequence   = verdict_out.icmp_sequence;
                got.udp_source_port = verdict_out.udp_source_port;
                got.udp_dest_port   = verdict_out.udp_dest_port;
                got.frame_length    = verdict_out.frame_length;
                verdicts.compare_verdict(got);
            end
            if (stall_left > 0)
            begin
                verdict_out.ready <= 1'b0;
                stall_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD_CYCLES - 1;
                verdict_out.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                verdict_out.ready <= 1'b0;
            end
            else
            begin
                verdict_out.ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, stimulus, drain, verdict
    initial
    begin
        frame_in.valid     <= 1'b0;
        frame_in.data_byte <= 8'h00;
        frame_in.last_byte <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        frame_in.valid <= 1'b0;

        while (verdicts.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (verdicts.mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
